>>> design/mat_pkg.sv
// ----------------------------------------------------------------------------
// Minute alarm table matcher package
// Shared constants, operation and result codes, and the transfer and
// table entry types of the alarm table matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mat_pkg;

   // Table geometry.
   localparam int NUM_ALARMS = 8;
   localparam int MAX_FIRED  = 8;
   localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int CNT_W      = $clog2(NUM_ALARMS + 1);
   localparam int FIRE_CNT_W = $clog2(MAX_FIRED + 1);

   // Request operations.
   localparam logic [1:0] OP_REGISTER   = 2'd0;
   localparam logic [1:0] OP_UNREGISTER = 2'd1;
   localparam logic [1:0] OP_TICK       = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_REGISTER   = 2'd0;
   localparam logic [1:0] KIND_UNREGISTER = 2'd1;
   localparam logic [1:0] KIND_FIRED      = 2'd2;
   localparam logic [1:0] KIND_TICK_END   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  slot;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic        repeat_mode;
      logic [6:0]  weekday_mask;
      logic        start_armed;
      logic [2:0]  weekday_now;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] result_slot;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // One stored alarm. Occupancy (free or not) lives in flip-flops in the
   // controller; the memory holds armed/off and the alarm fields.
   typedef struct packed {
      logic        armed;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic        repeat_mode;
      logic [6:0]  weekday_mask;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic    strobe;
      rsp_type data;
   } rsp_pend_type;

endpackage

>>> design/mat_table.sv
// ----------------------------------------------------------------------------
// Alarm table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mat_table (
   input  logic                     clock,
   input  mat_pkg::mem_wr_type      wr,
   input  logic [mat_pkg::IDX_W-1:0] rd_addr,
   output mat_pkg::entry_type       rd_data
);

   mat_pkg::entry_type mem_ff [mat_pkg::NUM_ALARMS];
   mat_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mat_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm table controller
// Handles register and unregister in the accepting cycle and walks the
// table one slot per cycle on a minute tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mat_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  mat_pkg::req_type          req,
   output logic                      busy,
   output mat_pkg::mem_wr_type       wr,
   output logic [mat_pkg::IDX_W-1:0] rd_addr,
   input  mat_pkg::entry_type        rd_data,
   output mat_pkg::rsp_pend_type     rsp_pend
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [mat_pkg::NUM_ALARMS-1:0]     valid_ff, valid_in;
   logic [mat_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [mat_pkg::IDX_W-1:0]          eval_slot_ff, eval_slot_in;
   logic [mat_pkg::FIRE_CNT_W-1:0]     fire_cnt_ff, fire_cnt_in;
   mat_pkg::req_type                   tick_ff, tick_in;

   logic                      have_free;
   logic [mat_pkg::IDX_W-1:0] free_idx;
   logic [mat_pkg::IDX_W-1:0] unreg_idx;
   logic                      last_slot;
   logic                      hit;
   logic                      date_eq;
   logic                      fire;
   logic                      disarm;

   function automatic logic day_selected(input logic [6:0] mask, input logic [2:0] wd);
      logic sel;
      sel = 1'b0;
      case (wd)
         3'd0:    sel = mask[6];
         3'd1:    sel = mask[0];
         3'd2:    sel = mask[1];
         3'd3:    sel = mask[2];
         3'd4:    sel = mask[3];
         3'd5:    sel = mask[4];
         3'd6:    sel = mask[5];
         default: sel = 1'b0;
      endcase
      return sel;
   endfunction

   // Lowest free slot.
   always_comb begin
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = mat_pkg::NUM_ALARMS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            have_free = 1'b1;
            free_idx  = mat_pkg::IDX_W'(i);
         end
      end
   end

   assign unreg_idx = mat_pkg::IDX_W'(req.slot);
   assign last_slot = (eval_slot_ff == mat_pkg::IDX_W'(mat_pkg::NUM_ALARMS - 1));

   // Slot evaluation for the tick walk.
   assign hit = valid_ff[eval_slot_ff] && rd_data.armed &&
                (rd_data.hour == tick_ff.hour) && (rd_data.minute == tick_ff.minute);
   assign date_eq = (rd_data.year == tick_ff.year) && (rd_data.month == tick_ff.month) &&
                    (rd_data.day == tick_ff.day);

   always_comb begin
      fire   = 1'b0;
      disarm = 1'b0;
      if (hit) begin
         if (rd_data.year != '0) begin
            fire   = date_eq;
            disarm = date_eq;
         end else if (!rd_data.repeat_mode) begin
            fire   = 1'b1;
            disarm = 1'b1;
         end else begin
            fire = day_selected(rd_data.weekday_mask, tick_ff.weekday_now);
         end
      end
   end

   // The read of the next slot and the write-back of the current one always
   // address different entries, so no forwarding is needed.
   always_comb begin
      if (state_ff == ST_WALK && !last_slot) begin
         rd_addr = eval_slot_ff + 1'b1;
      end else begin
         rd_addr = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      eval_slot_in = eval_slot_ff;
      fire_cnt_in  = fire_cnt_ff;
      tick_in      = tick_ff;
      wr           = '0;
      rsp_pend     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req.opcode)
                  mat_pkg::OP_REGISTER: begin
                     rsp_pend.strobe    = 1'b1;
                     rsp_pend.data.kind = mat_pkg::KIND_REGISTER;
                     rsp_pend.data.last = 1'b1;
                     if (have_free) begin
                        wr.en                   = 1'b1;
                        wr.addr                 = free_idx;
                        wr.data.armed           = req.start_armed;
                        wr.data.year            = req.year;
                        wr.data.month           = req.month;
                        wr.data.day             = req.day;
                        wr.data.hour            = req.hour;
                        wr.data.minute          = req.minute;
                        wr.data.repeat_mode     = req.repeat_mode;
                        wr.data.weekday_mask    = req.weekday_mask;
                        valid_in[free_idx]      = 1'b1;
                        if (count_ff < mat_pkg::CNT_W'(mat_pkg::NUM_ALARMS)) begin
                           count_in = count_ff + 1'b1;
                        end
                        rsp_pend.data.result_slot = 3'(free_idx);
                        rsp_pend.data.status      = mat_pkg::STATUS_OK;
                     end else begin
                        rsp_pend.data.status = mat_pkg::STATUS_FULL;
                     end
                  end
                  mat_pkg::OP_UNREGISTER: begin
                     rsp_pend.strobe           = 1'b1;
                     rsp_pend.data.kind        = mat_pkg::KIND_UNREGISTER;
                     rsp_pend.data.result_slot = req.slot;
                     rsp_pend.data.last        = 1'b1;
                     if (count_ff == '0) begin
                        rsp_pend.data.status = mat_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_pend.data.status = mat_pkg::STATUS_OK;
                        count_in             = count_ff - 1'b1;
                        if (int'(req.slot) < mat_pkg::NUM_ALARMS) begin
                           valid_in[unreg_idx] = 1'b0;
                        end
                     end
                  end
                  mat_pkg::OP_TICK: begin
                     tick_in      = req;
                     eval_slot_in = '0;
                     fire_cnt_in  = '0;
                     state_in     = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (disarm) begin
               wr.en         = 1'b1;
               wr.addr       = eval_slot_ff;
               wr.data       = rd_data;
               wr.data.armed = 1'b0;
            end
            if (fire && fire_cnt_ff < mat_pkg::FIRE_CNT_W'(mat_pkg::MAX_FIRED)) begin
               rsp_pend.strobe           = 1'b1;
               rsp_pend.data.kind        = mat_pkg::KIND_FIRED;
               rsp_pend.data.result_slot = 3'(eval_slot_ff);
               rsp_pend.data.status      = mat_pkg::STATUS_OK;
               fire_cnt_in               = fire_cnt_ff + 1'b1;
            end
            if (last_slot) begin
               state_in = ST_DONE;
            end else begin
               eval_slot_in = eval_slot_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rsp_pend.strobe    = 1'b1;
            rsp_pend.data.kind = mat_pkg::KIND_TICK_END;
            rsp_pend.data.last = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         count_ff    <= '0;
         fire_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         fire_cnt_ff <= fire_cnt_in;
      end
      eval_slot_ff <= eval_slot_in;
      tick_ff      <= tick_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> design/minute_alarm_table_matcher.sv
// ----------------------------------------------------------------------------
// Minute alarm table matcher
// A table of alarm slots that takes register, unregister and minute tick
// commands and reports slot assignments and fired alarms.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                        Transfer
//   request    start, busy, req_data        start high while busy is low
//   result     rsp_strobe, rsp_data         rsp_strobe high for one cycle
//
// A register or unregister command is taken without raising busy, and its
// reply appears on the result ports in the following cycle.
// A minute tick holds busy high through the table walk and the tick end
// state. The walk reads one slot per cycle through the memory's single
// read port, while the previous slot is compared and written back.
// Synchronous reset frees every slot at once and clears the count; there
// is no clearing pass. The receiver takes every result as it is shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minute_alarm_table_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mat_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mat_pkg::rsp_type rsp_data
);

   mat_pkg::mem_wr_type       mem_wr;
   logic [mat_pkg::IDX_W-1:0] mem_rd_addr;
   mat_pkg::entry_type        mem_rd_data;
   mat_pkg::rsp_pend_type     rsp_pend;

   logic             rsp_strobe_ff;
   mat_pkg::rsp_type rsp_data_ff;

   // The controller decides every result; the occupancy bits and the alarm
   // count sit in its flip-flops, the alarm fields in the table memory.
   mat_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .busy     (busy),
      .wr       (mem_wr),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data),
      .rsp_pend (rsp_pend)
   );

   mat_table u_table (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: each result is shown for exactly one cycle. The data
   // field is only meaningful while the strobe is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_pend.strobe;
      end
      rsp_data_ff <= rsp_pend.data;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> design/mat_port_checker.sv
// ----------------------------------------------------------------------------
// Alarm table matcher port checker
// Checks reply timing and result framing on the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mat_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mat_pkg::req_type req_data,
   input logic             rsp_strobe,
   input mat_pkg::rsp_type rsp_data
);

   // A register command is answered in the very next cycle, alone.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.opcode == mat_pkg::OP_REGISTER) |=>
      (rsp_strobe && rsp_data.kind == mat_pkg::KIND_REGISTER && rsp_data.last))
      else $error("register reply missing or malformed");

   // An unregister command is answered in the next cycle with its slot.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.opcode == mat_pkg::OP_UNREGISTER) |=>
      (rsp_strobe && rsp_data.kind == mat_pkg::KIND_UNREGISTER && rsp_data.last &&
       rsp_data.result_slot == $past(req_data.slot)))
      else $error("unregister reply missing or malformed");

   // A tick locks out further commands until its walk is over.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.opcode == mat_pkg::OP_TICK) |=> busy)
      else $error("tick accepted without raising busy");

   // Fired results never close a run; only the tick end does.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.kind == mat_pkg::KIND_FIRED) |->
      (!rsp_data.last && rsp_data.status == mat_pkg::STATUS_OK))
      else $error("fired result marked last or with bad status");

   // The tick end arrives as busy drops, never while idle for a while.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.kind == mat_pkg::KIND_TICK_END) |->
      ($past(busy) && !busy && rsp_data.last))
      else $error("tick end out of place");

endmodule

bind minute_alarm_table_matcher mat_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

>>> verif/minute_alarm_table_matcher_tb.sv
// ----------------------------------------------------------------------------
// Minute alarm table matcher testbench
// Drives register, unregister and minute tick commands into the alarm table,
// predicts every reply, fired alarm and tick end from a behavioural copy of
// the table, and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minute_alarm_table_matcher_tb;

   import mat_pkg::*;

   // The opcode that the block must ignore without any result.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Number of counted random commands after the directed part.
   localparam int RANDOM_COMMANDS = 345;
   // Cycle limit. The slowest correct run is far below this.
   localparam int CYCLE_LIMIT     = 200000;
   // Cycles to let pass after the last expected result, for stray results.
   localparam int TAIL_CYCLES     = NUM_ALARMS + 6;
   localparam int MAX_REPORTS     = 10;

   // Occupancy of one slot in the predicted table.
   typedef enum logic [1:0] {
      SLOT_FREE,
      SLOT_ARMED,
      SLOT_OFF
   } slot_state_type;

   typedef struct packed {
      slot_state_type occ;
      logic [11:0]    year;
      logic [3:0]     month;
      logic [4:0]     day;
      logic [4:0]     hour;
      logic [5:0]     minute;
      logic           repeat_mode;
      logic [6:0]     weekday_mask;
   } alarm_slot_type;

   // One row of the directed stimulus. Where typed is set, the reply is
   // written out by hand and replaces the predicted one.
   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type reply;
   } directed_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Predicted table state.
   alarm_slot_type       alarm_slots [NUM_ALARMS];
   logic [CNT_W-1:0]     alarm_total;

   // Results still to come, oldest first.
   rsp_type              expected_replies [$];
   directed_row_type     directed_rows [$];

   int unsigned          error_count    = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count    = 0;
   int unsigned          burst_left     = 0;

   minute_alarm_table_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Helpers to build commands and replies.
   // ------------------------------------------------------------------------
   function automatic req_type make_req(input logic [1:0] op, input int slot,
                                        input int year, input int month,
                                        input int day, input int hour,
                                        input int minute, input bit rep,
                                        input logic [6:0] mask, input bit armed,
                                        input int wd);
      req_type r;
      r.opcode       = op;
      r.slot         = slot[2:0];
      r.year         = year[11:0];
      r.month        = month[3:0];
      r.day          = day[4:0];
      r.hour         = hour[4:0];
      r.minute       = minute[5:0];
      r.repeat_mode  = rep;
      r.weekday_mask = mask;
      r.start_armed  = armed;
      r.weekday_now  = wd[2:0];
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] kind, input int slot,
                                        input logic [1:0] status);
      rsp_type r;
      r.kind        = kind;
      r.result_slot = slot[2:0];
      r.status      = status;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input req_type cmd, input bit typed,
                                   input rsp_type reply);
      directed_row_type row;
      row.cmd   = cmd;
      row.typed = typed;
      row.reply = reply;
      directed_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Predictor. Applies one accepted command to the predicted table and
   // returns the results it causes, in order.
   // ------------------------------------------------------------------------
   function automatic bit weekday_enabled(input logic [6:0] mask,
                                          input logic [2:0] wd);
      // Sunday is the top mask bit; Monday to Saturday use bits 0 to 5.
      // A weekday of seven selects nothing.
      if (wd == 3'd0)
         return mask[6];
      if (wd <= 3'd6)
         return mask[wd - 3'd1];
      return 1'b0;
   endfunction

   function automatic void predict_table_outcome(input req_type cmd,
                                                 output rsp_type outcome [$]);
      rsp_type r;
      int      fired;
      bit      hit;
      bit      placed;
      outcome = {};
      r       = '0;
      case (cmd.opcode)
         OP_REGISTER: begin
            // The lowest free slot takes the alarm; a full table is untouched.
            placed = 1'b0;
            for (int i = 0; i < NUM_ALARMS && !placed; i++) begin
               if (alarm_slots[i].occ == SLOT_FREE) begin
                  alarm_slots[i].occ          = cmd.start_armed ? SLOT_ARMED : SLOT_OFF;
                  alarm_slots[i].year         = cmd.year;
                  alarm_slots[i].month        = cmd.month;
                  alarm_slots[i].day          = cmd.day;
                  alarm_slots[i].hour         = cmd.hour;
                  alarm_slots[i].minute       = cmd.minute;
                  alarm_slots[i].repeat_mode  = cmd.repeat_mode;
                  alarm_slots[i].weekday_mask = cmd.weekday_mask;
                  if (alarm_total < NUM_ALARMS)
                     alarm_total++;
                  outcome.push_back(make_rsp(KIND_REGISTER, i, STATUS_OK));
                  placed = 1'b1;
               end
            end
            if (!placed)
               outcome.push_back(make_rsp(KIND_REGISTER, 0, STATUS_FULL));
         end
         OP_UNREGISTER: begin
            // Only the count decides failure: freeing a free or off slot
            // still lowers the count.
            if (alarm_total == 0) begin
               outcome.push_back(make_rsp(KIND_UNREGISTER, cmd.slot, STATUS_EMPTY));
            end else begin
               if (cmd.slot < NUM_ALARMS)
                  alarm_slots[cmd.slot].occ = SLOT_FREE;
               alarm_total--;
               outcome.push_back(make_rsp(KIND_UNREGISTER, cmd.slot, STATUS_OK));
            end
         end
         OP_TICK: begin
            fired = 0;
            for (int i = 0; i < NUM_ALARMS; i++) begin
               hit = 1'b0;
               if (alarm_slots[i].occ == SLOT_ARMED &&
                   alarm_slots[i].hour == cmd.hour &&
                   alarm_slots[i].minute == cmd.minute) begin
                  if (alarm_slots[i].year != 0) begin
                     if (alarm_slots[i].year == cmd.year &&
                         alarm_slots[i].month == cmd.month &&
                         alarm_slots[i].day == cmd.day) begin
                        hit = 1'b1;
                        alarm_slots[i].occ = SLOT_OFF;
                     end
                  end else if (!alarm_slots[i].repeat_mode) begin
                     hit = 1'b1;
                     alarm_slots[i].occ = SLOT_OFF;
                  end else begin
                     hit = weekday_enabled(alarm_slots[i].weekday_mask,
                                           cmd.weekday_now);
                  end
               end
               if (hit && fired < MAX_FIRED) begin
                  r             = '0;
                  r.kind        = KIND_FIRED;
                  r.result_slot = i[2:0];
                  r.status      = STATUS_OK;
                  r.last        = 1'b0;
                  outcome.push_back(r);
                  fired++;
               end
            end
            outcome.push_back(make_rsp(KIND_TICK_END, 0, STATUS_OK));
         end
         default: begin
            // The unused opcode is ignored.
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Random commands. Most are well formed and use a small pool of times and
   // dates, so that ticks meet stored alarms and often fire several at once.
   // The rest is raw noise over every bit of every field.
   // ------------------------------------------------------------------------
   function automatic req_type draw_random_command();
      req_type     r;
      logic [63:0] raw;
      int          pick;
      int          pool;
      int          busy_slots [$];
      raw  = {$urandom, $urandom};
      r    = raw[$bits(req_type)-1:0];
      if ($urandom_range(0, 99) < 12)
         return r;
      pool     = $urandom_range(0, 2);
      r.hour   = (pool == 0) ? 5'd0 : (pool == 1) ? 5'd12 : 5'd23;
      r.minute = (pool == 0) ? 6'd0 : (pool == 1) ? 6'd30 : 6'd59;
      r.month  = $urandom_range(0, 1) ? 4'd12 : 4'd1;
      r.day    = $urandom_range(0, 1) ? 5'd31 : 5'd1;
      pick     = $urandom_range(0, 99);
      if (pick < 35) begin
         r.opcode      = OP_REGISTER;
         r.year        = ($urandom_range(0, 1) == 0) ? 12'd0 :
                         ($urandom_range(0, 1) == 0) ? 12'd2024 : 12'd4095;
         r.start_armed = ($urandom_range(0, 99) < 85);
      end else if (pick < 55) begin
         r.opcode = OP_UNREGISTER;
         foreach (alarm_slots[i])
            if (alarm_slots[i].occ != SLOT_FREE)
               busy_slots.push_back(i);
         if (busy_slots.size() != 0 && $urandom_range(0, 99) < 75)
            r.slot = 3'(busy_slots[$urandom_range(0, busy_slots.size() - 1)]);
      end else if (pick < 97) begin
         r.opcode      = OP_TICK;
         r.year        = $urandom_range(0, 1) ? 12'd2024 : 12'd4095;
         r.weekday_now = ($urandom_range(0, 99) < 5) ? 3'd7 :
                         3'($urandom_range(0, 6));
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   // Idle cycles before the next command: sometimes a run of back-to-back
   // transfers, otherwise a fresh random draw.
   function automatic int unsigned draw_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         burst_left = $urandom_range(8, 20);
      return $urandom_range(0, 6);
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Called at a rising edge. Lowers start only when a pause follows,
   // so start is never lowered and raised in the same step. With drain set,
   // it first waits until every expected result has arrived. The command is
   // predicted at the edge where it is accepted.
   // ------------------------------------------------------------------------
   task automatic send_command(input req_type cmd, input int unsigned gap,
                               input bit drain, input bit typed,
                               input rsp_type reply);
      rsp_type outcome [$];
      if (drain || gap != 0)
         start <= 1'b0;
      if (drain) begin
         @(posedge clock);
         while (expected_replies.size() != 0)
            @(posedge clock);
      end
      repeat (gap) @(posedge clock);
      start    <= 1'b1;
      req_data <= cmd;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      predict_table_outcome(cmd, outcome);
      if (typed)
         expected_replies.push_back(reply);
      else
         foreach (outcome[k])
            expected_replies.push_back(outcome[k]);
   endtask

   // ------------------------------------------------------------------------
   // Result checker. Each strobed result is compared field by field with the
   // oldest expectation; a result with nothing expected is a failure too.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_replies.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: kind %0d slot %0d status %0d last %0d",
                        rsp_data.kind, rsp_data.result_slot, rsp_data.status,
                        rsp_data.last);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_strobe !== 1'b1 ||
                rsp_data.kind !== want.kind ||
                rsp_data.result_slot !== want.result_slot ||
                rsp_data.status !== want.status ||
                rsp_data.last !== want.last) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"result mismatch: expected kind %0d slot %0d status %0d ",
                            "last %0d, got kind %0d slot %0d status %0d last %0d"},
                           want.kind, want.result_slot, want.status, want.last,
                           rsp_data.kind, rsp_data.result_slot, rsp_data.status,
                           rsp_data.last);
            end
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin
      req_type     cmd;
      int unsigned counted;

      for (int i = 0; i < NUM_ALARMS; i++)
         alarm_slots[i] = '0;
      alarm_total = '0;

      // Directed part. Right after reset the table is empty, so unregister
      // reports an empty table and a tick reports only its end.
      add_row(make_req(OP_UNREGISTER, 0, 0, 0, 0, 0, 0, 0, 7'h00, 0, 0), 1,
              make_rsp(KIND_UNREGISTER, 0, STATUS_EMPTY));
      add_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 7'h00, 0, 0), 1,
              make_rsp(KIND_TICK_END, 0, STATUS_OK));
      // Fill all eight slots: a dated alarm at the field maxima, undated
      // single and repetitive alarms, one held off and one dated at the minima.
      add_row(make_req(OP_REGISTER, 0, 4095, 12, 31, 23, 59, 0, 7'h00, 1, 0), 1,
              make_rsp(KIND_REGISTER, 0, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 0, 0, 0, 7'h00, 1, 0), 1,
              make_rsp(KIND_REGISTER, 1, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 0, 0, 1, 7'h7F, 1, 0), 1,
              make_rsp(KIND_REGISTER, 2, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 0, 0, 1, 7'h40, 1, 0), 1,
              make_rsp(KIND_REGISTER, 3, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 0, 0, 0, 7'h00, 0, 0), 1,
              make_rsp(KIND_REGISTER, 4, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 1, 1, 1, 0, 0, 0, 7'h00, 1, 0), 1,
              make_rsp(KIND_REGISTER, 5, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 0, 0, 1, 7'h01, 1, 0), 1,
              make_rsp(KIND_REGISTER, 6, STATUS_OK));
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 23, 59, 0, 7'h00, 1, 0), 1,
              make_rsp(KIND_REGISTER, 7, STATUS_OK));
      // The table is now full: the reply carries slot zero and nothing moves.
      add_row(make_req(OP_REGISTER, 7, 4095, 15, 31, 31, 63, 1, 7'h7F, 1, 7), 1,
              make_rsp(KIND_REGISTER, 0, STATUS_FULL));
      // Ticks: a Sunday midnight on the dated alarm's date, a weekday beyond
      // Saturday, the maximum date and time, and a Monday midnight.
      add_row(make_req(OP_TICK, 0, 1, 1, 1, 0, 0, 0, 7'h00, 0, 0), 0, '0);
      add_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 7'h00, 0, 7), 0, '0);
      add_row(make_req(OP_TICK, 0, 4095, 12, 31, 23, 59, 0, 7'h00, 0, 1), 0, '0);
      add_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 7'h00, 0, 1), 0, '0);
      // Unregister the held-off slot, then the same slot again while free.
      add_row(make_req(OP_UNREGISTER, 4, 0, 0, 0, 0, 0, 0, 7'h00, 0, 0), 1,
              make_rsp(KIND_UNREGISTER, 4, STATUS_OK));
      add_row(make_req(OP_UNREGISTER, 4, 0, 0, 0, 0, 0, 0, 7'h00, 0, 0), 1,
              make_rsp(KIND_UNREGISTER, 4, STATUS_OK));
      // The unused opcode with every other bit set causes nothing.
      add_row(make_req(OP_UNUSED, 7, 4095, 15, 31, 31, 63, 1, 7'h7F, 1, 7), 0, '0);
      // The freed slot is reused.
      add_row(make_req(OP_REGISTER, 0, 0, 0, 0, 12, 30, 1, 7'h3F, 1, 0), 1,
              make_rsp(KIND_REGISTER, 4, STATUS_OK));
      add_row(make_req(OP_UNREGISTER, 7, 0, 0, 0, 0, 0, 0, 7'h00, 0, 0), 1,
              make_rsp(KIND_UNREGISTER, 7, STATUS_OK));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         send_command(directed_rows[n].cmd, draw_gap(), 1'b0,
                      directed_rows[n].typed, directed_rows[n].reply);

      // Random part. The sender lets the block run dry before the first
      // random command and then every so often.
      counted = 0;
      while (counted < RANDOM_COMMANDS) begin
         cmd = draw_random_command();
         send_command(cmd, draw_gap(), (counted % 64) == 0, 1'b0, '0);
         if (cmd.opcode != OP_UNUSED)
            counted++;
      end
      start <= 1'b0;

      // Let the last results arrive, then watch a little longer for strays.
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_replies.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
